// ----- hdl/fkdt_pkg.sv -----
// Shared types and constants for the four-key debounce and toggle unit.
// Used by fkdt_core, the top level and fkdt_checker; depends on nothing else.
package fkdt_pkg;

    localparam int KEY_COUNT     = 4;
    localparam int SETTLE_W      = 8;
    localparam int EVENT_W       = 3;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 8;

    localparam logic [SETTLE_W-1:0]  SETTLE_RESET = 8'd4;
    localparam logic [KEY_COUNT-1:0] MASK_RESET   = 4'd0;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SETTLE_SAMPLES   = 1'b0,
        CFG_ACTIVE_HIGH_MASK = 1'b1
    } t_cfg_index;

    // Event codes; key k reports as k + 1
    localparam logic [EVENT_W-1:0] EVENT_NONE = 3'd0;

    // One result: bit 0 lamp, 1 uv, 2 fan, 3 socket in device_on
    typedef struct packed {
        logic [KEY_COUNT-1:0] device_on;
        logic [EVENT_W-1:0]   event_key;
    } t_result;

endpackage

// ----- hdl/four_key_debounce_toggle_unit.sv -----
// Four-key debounce and toggle unit: input register, fkdt_core, two-entry result buffer.
// A sample waits in the input register until the buffer has room; the core then steps and
// its result is written into the result buffer, whose head is shown on m_axis.
// Throughput: one sample per cycle; s_axis_tready falls only when the input register and
// both result entries are full and no result is taken in that cycle.
// Reset (i_rst_n, synchronous, active low) clears counters, arming, status bits and
// the buffers, and sets settle_samples to 4 and active_high_mask to 0.
module four_key_debounce_toggle_unit
    import fkdt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_wen,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Sample requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] key_levels, [7:4] zero
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // Result requests
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] event_key, [3] lamp_on, [4] uv_on, [5] fan_on, [6] socket_on, [7] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata
);

    logic [SETTLE_W-1:0]  r_settle;
    logic [KEY_COUNT-1:0] r_mask;
    logic                 r_in_valid;
    logic [KEY_COUNT-1:0] r_in_levels;
    t_result              r_buf0, r_buf1;
    logic [1:0]           r_cnt;
    t_result              core_result;
    logic                 s_accept, m_accept, advance, room;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_RESET;
            r_mask   <= MASK_RESET;
        end else if (i_cfg_wen) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SETTLE_SAMPLES:   r_settle <= i_cfg_wdata[SETTLE_W-1:0];
                CFG_ACTIVE_HIGH_MASK: r_mask   <= i_cfg_wdata[KEY_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // Handshake control
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign room          = (r_cnt != 2'd2) || m_accept;
    assign advance       = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || room;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_levels <= s_axis_tdata[KEY_COUNT-1:0];
        end
    end

    fkdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_levels (r_in_levels),
        .i_settle (r_settle),
        .i_mask   (r_mask),
        .o_result (core_result)
    );

    // Two-entry result buffer, head in r_buf0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({advance, m_accept})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({advance, m_accept})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_buf0 <= core_result;
                end else begin
                    r_buf1 <= core_result;
                end
            end
            2'b01: begin
                r_buf0 <= r_buf1;
            end
            2'b11: begin
                if (r_cnt == 2'd2) begin
                    r_buf0 <= r_buf1;
                    r_buf1 <= core_result;
                end else begin
                    r_buf0 <= core_result;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {1'b0, r_buf0.device_on, r_buf0.event_key};

endmodule

// ----- hdl/fkdt_core.sv -----
// Per-key debounce counters, press arming and device status toggling.
// Depends on fkdt_pkg for widths and the result type.
module fkdt_core
    import fkdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [KEY_COUNT-1:0] i_levels,
    input  logic [SETTLE_W-1:0]  i_settle,
    input  logic [KEY_COUNT-1:0] i_mask,
    output t_result              o_result
);

    logic [SETTLE_W-1:0]  r_count [KEY_COUNT];
    logic [SETTLE_W-1:0]  n_count [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_stable, n_stable;
    logic [KEY_COUNT-1:0] r_held, n_held;
    logic [KEY_COUNT-1:0] r_device, n_device;
    logic [EVENT_W-1:0]   n_event;

    // Next state of every key for the sample in the input register
    always_comb begin
        logic [SETTLE_W:0]    inc;
        logic [SETTLE_W:0]    limit;
        logic [KEY_COUNT-1:0] pressed_now;
        pressed_now = ~(i_levels ^ i_mask);
        // A threshold of zero behaves as one
        limit = (i_settle == '0) ? (SETTLE_W+1)'(1) : {1'b0, i_settle};
        n_event = EVENT_NONE;
        for (int k = 0; k < KEY_COUNT; k++) begin
            inc = {1'b0, r_count[k]} + (SETTLE_W+1)'(1);
            n_stable[k] = r_stable[k];
            if (pressed_now[k] != r_stable[k]) begin
                if (inc >= limit) begin
                    n_stable[k] = pressed_now[k];
                    n_count[k]  = '0;
                end else begin
                    n_count[k]  = inc[SETTLE_W-1:0];
                end
            end else begin
                n_count[k] = '0;
            end
            // The highest newly pressed armed key wins the report
            if (n_stable[k]) begin
                if (!r_held[k]) begin
                    n_event = EVENT_W'(k + 1);
                end
                n_held[k] = 1'b1;
            end else begin
                n_held[k] = 1'b0;
            end
        end
        n_device = r_device;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (n_event == EVENT_W'(k + 1)) begin
                n_device[k] = ~r_device[k];
            end
        end
    end

    // State advances once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_count[k] <= '0;
            end
            r_stable <= '0;
            r_held   <= '0;
            r_device <= '0;
        end else if (i_step) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_count[k] <= n_count[k];
            end
            r_stable <= n_stable;
            r_held   <= n_held;
            r_device <= n_device;
        end
    end

    assign o_result.event_key = n_event;
    assign o_result.device_on = n_device;

endmodule

// ----- hdl/fkdt_checker.sv -----
// Port-level checks for four_key_debounce_toggle_unit, bound to the top level.
// Depends on fkdt_pkg for port widths.
module fkdt_checker
    import fkdt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only when a result is waiting
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("sample refused with no result pending");

    // Event code stays within the four keys
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4) && !m_axis_tdata[7])
        else $error("event code out of range");

    // A stalled result request holds its data
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind four_key_debounce_toggle_unit fkdt_checker u_fkdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
